### hw/rtl/gsst_pkg.sv
`default_nettype none
package gsst_pkg;
	localparam logic [2:0] SYS_GPS = 3'd0;
	localparam logic [2:0] SYS_GLO = 3'd1;
	localparam logic [2:0] SYS_GAL = 3'd2;
	localparam logic [2:0] SYS_BDS = 3'd3;
	localparam logic [2:0] SYS_QZS = 3'd4;
	localparam logic [2:0] SYS_SBS = 3'd5;
	localparam logic [2:0] SYS_NAV = 3'd6;
	localparam logic [2:0] SYS_UNK = 3'd7;

	localparam logic [2:0] ST_UPDATED = 3'd0;
	localparam logic [2:0] ST_INSERTED = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_UNATTR = 3'd3;
	localparam logic [2:0] ST_EMPTY = 3'd4;
	localparam logic [2:0] ST_SWEPT = 3'd5;

	localparam logic [0:0] REG_SIGNAL_TIMEOUT = 1'b0;
	localparam logic [0:0] REG_USED_TIMEOUT = 1'b1;

	localparam logic [31:0] TIMEOUT_RESET = 32'd10000;
	localparam logic [7:0] CNO_MAX = 8'd99;

	typedef struct packed {
		logic [2:0] sys;
		logic [1:0] band;
		logic [7:0] prn;
	} sig_key_t;

	typedef struct packed {
		logic [6:0] cno;
		logic [8:0] azimuth;
		logic [7:0] elevation;
	} sig_val_t;

	typedef struct packed {
		sig_key_t key;
		sig_val_t val;
		logic [31:0] stamp;
	} sig_entry_t;

	typedef struct packed {
		logic [2:0] sys;
		logic [7:0] prn;
	} used_key_t;

	typedef struct packed {
		used_key_t key;
		logic [31:0] stamp;
	} used_entry_t;

	typedef struct packed {
		logic [2:0] sys;
		logic [7:0] prn;
		logic [1:0] band;
	} class_t;
endpackage
`default_nettype wire

### hw/rtl/gnss_satellite_signal_tracker.sv
// Empty-PRN and unattributable reports go straight to the result; a signal report walks the
// signal table and then the used table, a used mark only the used table, and a sweep both
// tables. Each table is walked one entry a cycle through its memory port.
// One item at a time: start is taken only while busy is low, from the cycle after the result.
// Reset clears both fill counts and sets both timeouts to 10000; no clearing pass.
// The result is shown for one cycle on result_valid; the receiver cannot stall.
`default_nettype none
module gnss_satellite_signal_tracker #(
	parameter int SIGNAL_ENTRIES = 64,
	parameter int USED_ENTRIES = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] command,
	input wire logic [2:0] system,
	input wire logic [7:0] raw_prn,
	input wire logic [3:0] signal_id,
	input wire logic signed [7:0] elevation,
	input wire logic [8:0] azimuth,
	input wire logic [7:0] cno,
	input wire logic [31:0] now_ms,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [0:0] cfg_index,
	input wire logic [31:0] cfg_data,
	output logic result_valid,
	output logic [2:0] status,
	output logic [2:0] sat_system,
	output logic [7:0] sat_prn,
	output logic [1:0] band,
	output logic sat_used,
	output logic [6:0] signal_count,
	output logic [5:0] used_count
);
	localparam int SCW = $clog2(SIGNAL_ENTRIES + 1);
	localparam int SAW = (SIGNAL_ENTRIES > 1) ? $clog2(SIGNAL_ENTRIES) : 1;
	localparam int UCW = $clog2(USED_ENTRIES + 1);
	localparam int UAW = (USED_ENTRIES > 1) ? $clog2(USED_ENTRIES) : 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SSCAN = 2'd1;
	localparam logic [1:0] S_USCAN = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	gsst_pkg::sig_entry_t sig_mem [SIGNAL_ENTRIES];
	gsst_pkg::used_entry_t used_mem [USED_ENTRIES];
	gsst_pkg::sig_entry_t sig_rdata;
	gsst_pkg::used_entry_t used_rdata;

	logic [1:0] st_q;
	logic [31:0] sig_to_q, used_to_q;
	logic [SCW-1:0] sfill_q, sidx_q, skeep_q;
	logic [UCW-1:0] ufill_q, uidx_q, ukeep_q;
	logic spend_s1, upend_s1;
	logic [SAW-1:0] spidx_s1;
	logic [UAW-1:0] upidx_s1;
	logic sweep_q, mark_q;
	gsst_pkg::sig_key_t skey_q;
	gsst_pkg::sig_val_t sval_q;
	logic [31:0] now_q;
	logic [2:0] status_q, sys_q;
	logic [7:0] prn_q;
	logic [1:0] band_q;
	logic used_q;

	gsst_pkg::class_t cls;
	gsst_pkg::used_key_t ukey;

	logic s_issue, u_issue, s_match, u_match, s_keep, u_keep;
	logic s_we, u_we;
	logic [SAW-1:0] s_waddr;
	logic [UAW-1:0] u_waddr;
	gsst_pkg::sig_entry_t s_wdata;
	gsst_pkg::used_entry_t u_wdata;
	logic [31:0] s_age, u_age;

	gsst_classify u_classify (
		.system(system),
		.raw_prn(raw_prn),
		.signal_id(signal_id),
		.cls(cls)
	);

	assign ukey.sys = sys_q;
	assign ukey.prn = prn_q;

	assign s_issue = (st_q == S_SSCAN) && (sidx_q < sfill_q);
	assign u_issue = (st_q == S_USCAN) && (uidx_q < ufill_q);
	assign s_match = spend_s1 && (sig_rdata.key == skey_q);
	assign u_match = upend_s1 && (used_rdata.key == ukey);
	assign s_age = now_q - sig_rdata.stamp;
	assign u_age = now_q - used_rdata.stamp;
	assign s_keep = spend_s1 && (s_age <= sig_to_q);
	assign u_keep = upend_s1 && (u_age <= used_to_q);

	always_comb begin
		s_we = 1'b0;
		s_waddr = sfill_q[SAW-1:0];
		s_wdata.key = skey_q;
		s_wdata.val = sval_q;
		s_wdata.stamp = now_q;
		if (st_q == S_SSCAN) begin
			if (sweep_q) begin
				s_we = s_keep;
				s_waddr = skeep_q[SAW-1:0];
				s_wdata = sig_rdata;
			end else if (s_match) begin
				s_we = 1'b1;
				s_waddr = spidx_s1;
			end else if (!spend_s1 && !s_issue) begin
				s_we = (sfill_q < SCW'(SIGNAL_ENTRIES));
			end
		end
	end

	always_comb begin
		u_we = 1'b0;
		u_waddr = ufill_q[UAW-1:0];
		u_wdata.key = ukey;
		u_wdata.stamp = now_q;
		if (st_q == S_USCAN) begin
			if (sweep_q) begin
				u_we = u_keep;
				u_waddr = ukeep_q[UAW-1:0];
				u_wdata = used_rdata;
			end else if (mark_q) begin
				if (u_match) begin
					u_we = 1'b1;
					u_waddr = upidx_s1;
				end else if (!upend_s1 && !u_issue) begin
					u_we = (ufill_q < UCW'(USED_ENTRIES));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_issue) sig_rdata <= sig_mem[sidx_q[SAW-1:0]];
		if (s_we) sig_mem[s_waddr] <= s_wdata;
	end

	always_ff @(posedge clk) begin
		if (u_issue) used_rdata <= used_mem[uidx_q[UAW-1:0]];
		if (u_we) used_mem[u_waddr] <= u_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_to_q <= gsst_pkg::TIMEOUT_RESET;
			used_to_q <= gsst_pkg::TIMEOUT_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == gsst_pkg::REG_SIGNAL_TIMEOUT) sig_to_q <= cfg_data;
			else used_to_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && start) begin
			sweep_q <= command[1];
			mark_q <= command[0];
			skey_q.sys <= cls.sys;
			skey_q.band <= cls.band;
			skey_q.prn <= cls.prn;
			sval_q.cno <= (cno > gsst_pkg::CNO_MAX) ? gsst_pkg::CNO_MAX[6:0] : cno[6:0];
			sval_q.azimuth <= azimuth;
			sval_q.elevation <= elevation;
			now_q <= now_ms;
			used_q <= 1'b0;
			if (command[1]) begin
				status_q <= gsst_pkg::ST_SWEPT;
				sys_q <= 3'd0;
				prn_q <= 8'd0;
				band_q <= 2'd0;
			end else if (raw_prn == 8'd0) begin
				status_q <= gsst_pkg::ST_EMPTY;
				sys_q <= 3'd0;
				prn_q <= 8'd0;
				band_q <= 2'd0;
			end else if (cls.sys == gsst_pkg::SYS_UNK) begin
				status_q <= gsst_pkg::ST_UNATTR;
				sys_q <= cls.sys;
				prn_q <= cls.prn;
				band_q <= 2'd0;
			end else begin
				status_q <= gsst_pkg::ST_FULL;
				sys_q <= cls.sys;
				prn_q <= cls.prn;
				band_q <= cls.band;
			end
		end else if (st_q == S_SSCAN && !sweep_q) begin
			if (s_match) status_q <= gsst_pkg::ST_UPDATED;
			else if (!spend_s1 && !s_issue && s_we) status_q <= gsst_pkg::ST_INSERTED;
		end else if (st_q == S_USCAN && !sweep_q) begin
			if (u_match) begin
				used_q <= 1'b1;
				if (mark_q) status_q <= gsst_pkg::ST_UPDATED;
			end else if (mark_q && !upend_s1 && !u_issue && u_we) begin
				used_q <= 1'b1;
				status_q <= gsst_pkg::ST_INSERTED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			sfill_q <= '0;
			ufill_q <= '0;
			sidx_q <= '0;
			uidx_q <= '0;
			skeep_q <= '0;
			ukeep_q <= '0;
			spend_s1 <= 1'b0;
			upend_s1 <= 1'b0;
			spidx_s1 <= '0;
			upidx_s1 <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					sidx_q <= '0;
					uidx_q <= '0;
					skeep_q <= '0;
					ukeep_q <= '0;
					spend_s1 <= 1'b0;
					upend_s1 <= 1'b0;
					if (start) begin
						if (command[1]) st_q <= S_SSCAN;
						else if (raw_prn == 8'd0 || cls.sys == gsst_pkg::SYS_UNK) st_q <= S_DONE;
						else if (command[0]) st_q <= S_USCAN;
						else st_q <= S_SSCAN;
					end
				end
				S_SSCAN: begin
					spend_s1 <= s_issue;
					spidx_s1 <= sidx_q[SAW-1:0];
					if (s_issue) sidx_q <= sidx_q + SCW'(1);
					if (sweep_q && s_keep) skeep_q <= skeep_q + SCW'(1);
					if (!sweep_q && s_match) begin
						spend_s1 <= 1'b0;
						st_q <= S_USCAN;
					end else if (!spend_s1 && !s_issue) begin
						if (sweep_q) sfill_q <= skeep_q;
						else if (s_we) sfill_q <= sfill_q + SCW'(1);
						st_q <= S_USCAN;
					end
				end
				S_USCAN: begin
					upend_s1 <= u_issue;
					upidx_s1 <= uidx_q[UAW-1:0];
					if (u_issue) uidx_q <= uidx_q + UCW'(1);
					if (sweep_q && u_keep) ukeep_q <= ukeep_q + UCW'(1);
					if (!sweep_q && u_match) begin
						upend_s1 <= 1'b0;
						st_q <= S_DONE;
					end else if (!upend_s1 && !u_issue) begin
						if (sweep_q) ufill_q <= ukeep_q;
						else if (u_we) ufill_q <= ufill_q + UCW'(1);
						st_q <= S_DONE;
					end
				end
				S_DONE: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (st_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign result_valid = (st_q == S_DONE);
	assign status = status_q;
	assign sat_system = sys_q;
	assign sat_prn = prn_q;
	assign band = band_q;
	assign sat_used = used_q;
	assign signal_count = 7'(sfill_q);
	assign used_count = 6'(ufill_q);
endmodule
`default_nettype wire

### hw/rtl/gsst_classify.sv
`default_nettype none
module gsst_classify (
	input wire logic [2:0] system,
	input wire logic [7:0] raw_prn,
	input wire logic [3:0] signal_id,
	output gsst_pkg::class_t cls
);
	logic [2:0] sys;
	logic [7:0] prn;
	logic [1:0] band;

	always_comb begin
		sys = system;
		prn = raw_prn;
		if (system == gsst_pkg::SYS_GPS || system == gsst_pkg::SYS_SBS ||
				system == gsst_pkg::SYS_UNK) begin
			if (raw_prn >= 8'd33 && raw_prn <= 8'd64) begin
				sys = gsst_pkg::SYS_SBS;
				prn = raw_prn + 8'd87;
			end else if (raw_prn >= 8'd120 && raw_prn <= 8'd158) begin
				sys = gsst_pkg::SYS_SBS;
			end else if (raw_prn >= 8'd193 && raw_prn <= 8'd202) begin
				sys = gsst_pkg::SYS_QZS;
			end else if (raw_prn >= 8'd65 && raw_prn <= 8'd96) begin
				sys = gsst_pkg::SYS_GLO;
			end else if (raw_prn >= 8'd1 && raw_prn <= 8'd32) begin
				sys = gsst_pkg::SYS_GPS;
			end
		end
	end

	always_comb begin
		band = 2'd0;
		case (sys)
			gsst_pkg::SYS_GPS, gsst_pkg::SYS_QZS: begin
				if (signal_id == 4'd5 || signal_id == 4'd6) band = 2'd1;
				else if (signal_id == 4'd7 || signal_id == 4'd8) band = 2'd2;
			end
			gsst_pkg::SYS_GLO: begin
				if (signal_id == 4'd3 || signal_id == 4'd4) band = 2'd1;
			end
			gsst_pkg::SYS_GAL: begin
				if (signal_id == 4'd1) band = 2'd1;
				else if (signal_id == 4'd2 || signal_id == 4'd3) band = 2'd2;
			end
			gsst_pkg::SYS_BDS: begin
				if ((signal_id >= 4'd5 && signal_id <= 4'd7) || signal_id == 4'hB ||
						signal_id == 4'hC) band = 2'd1;
				else if (signal_id >= 4'd8 && signal_id <= 4'hA) band = 2'd2;
			end
			gsst_pkg::SYS_NAV: begin
				if (signal_id == 4'd2 || signal_id == 4'd4) band = 2'd1;
			end
			default: band = 2'd0;
		endcase
	end

	assign cls.sys = sys;
	assign cls.prn = prn;
	assign cls.band = band;
endmodule
`default_nettype wire

### sim/tracker_checker.sv
`timescale 1ns / 100ps
module tracker_checker
	import gsst_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic [1:0] command,
	input logic [2:0] system,
	input logic [7:0] raw_prn,
	input logic [3:0] signal_id,
	input logic [31:0] now_ms,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [31:0] cfg_data,
	input logic result_valid,
	input logic [2:0] status,
	input logic [2:0] sat_system,
	input logic [7:0] sat_prn,
	input logic [1:0] band,
	input logic sat_used,
	input logic [6:0] signal_count,
	input logic [5:0] used_count,
	output int fail_count,
	output int pending
);
	localparam int SIG_DEPTH = 64;
	localparam int USED_DEPTH = 32;

	typedef struct {
		logic [2:0] st;
		logic [2:0] sys;
		logic [7:0] prn;
		logic [1:0] bnd;
		logic used;
		logic [6:0] sig_cnt;
		logic [5:0] used_cnt;
	} outcome_t;

	outcome_t outcomes[$];
	logic [12:0] sig_key[SIG_DEPTH];
	logic [31:0] sig_stamp[SIG_DEPTH];
	int sig_fill;
	logic [10:0] used_key[USED_DEPTH];
	logic [31:0] used_stamp[USED_DEPTH];
	int used_fill;
	logic [31:0] sig_timeout;
	logic [31:0] used_timeout;

	function automatic logic [1:0] band_for(logic [2:0] s, logic [3:0] id);
		case (s)
			SYS_GPS, SYS_QZS: begin
				if (id == 4'd5 || id == 4'd6) return 2'd1;
				if (id == 4'd7 || id == 4'd8) return 2'd2;
				return 2'd0;
			end
			SYS_GLO: return (id == 4'd3 || id == 4'd4) ? 2'd1 : 2'd0;
			SYS_GAL: begin
				if (id == 4'd1) return 2'd1;
				if (id == 4'd2 || id == 4'd3) return 2'd2;
				return 2'd0;
			end
			SYS_BDS: begin
				if ((id >= 4'd5 && id <= 4'd7) || id == 4'hB || id == 4'hC) return 2'd1;
				if (id >= 4'd8 && id <= 4'hA) return 2'd2;
				return 2'd0;
			end
			SYS_NAV: return (id == 4'd2 || id == 4'd4) ? 2'd1 : 2'd0;
			default: return 2'd0;
		endcase
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	task automatic predict_transfer();
		outcome_t o;
		logic [2:0] s;
		logic [7:0] p;
		logic [12:0] k;
		logic [10:0] uk;
		int keep;
		bit hit;
		o = '{default: '0};
		if (command[1]) begin
			keep = 0;
			for (int i = 0; i < sig_fill; i++)
				if (now_ms - sig_stamp[i] <= sig_timeout) begin
					sig_key[keep] = sig_key[i];
					sig_stamp[keep] = sig_stamp[i];
					keep++;
				end
			sig_fill = keep;
			keep = 0;
			for (int i = 0; i < used_fill; i++)
				if (now_ms - used_stamp[i] <= used_timeout) begin
					used_key[keep] = used_key[i];
					used_stamp[keep] = used_stamp[i];
					keep++;
				end
			used_fill = keep;
			o.st = ST_SWEPT;
		end else if (raw_prn == 8'd0) begin
			o.st = ST_EMPTY;
		end else begin
			s = system;
			p = raw_prn;
			if (s == SYS_GPS || s == SYS_SBS || s == SYS_UNK) begin
				if (p >= 33 && p <= 64) begin
					p = p + 8'd87;
					s = SYS_SBS;
				end else if (p >= 120 && p <= 158) s = SYS_SBS;
				else if (p >= 193 && p <= 202) s = SYS_QZS;
				else if (p >= 65 && p <= 96) s = SYS_GLO;
				else if (p >= 1 && p <= 32) s = SYS_GPS;
			end
			o.sys = s;
			o.prn = p;
			if (s == SYS_UNK) begin
				o.st = ST_UNATTR;
			end else begin
				o.bnd = band_for(s, signal_id);
				hit = 0;
				if (command == 2'd0) begin
					k = {s, o.bnd, p};
					for (int i = 0; i < sig_fill && !hit; i++)
						if (sig_key[i] == k) begin
							sig_stamp[i] = now_ms;
							hit = 1;
						end
					if (hit) o.st = ST_UPDATED;
					else if (sig_fill < SIG_DEPTH) begin
						sig_key[sig_fill] = k;
						sig_stamp[sig_fill] = now_ms;
						sig_fill++;
						o.st = ST_INSERTED;
					end else o.st = ST_FULL;
				end else begin
					uk = {s, p};
					for (int i = 0; i < used_fill && !hit; i++)
						if (used_key[i] == uk) begin
							used_stamp[i] = now_ms;
							hit = 1;
						end
					if (hit) o.st = ST_UPDATED;
					else if (used_fill < USED_DEPTH) begin
						used_key[used_fill] = uk;
						used_stamp[used_fill] = now_ms;
						used_fill++;
						o.st = ST_INSERTED;
					end else o.st = ST_FULL;
				end
				for (int i = 0; i < used_fill; i++)
					if (used_key[i] == {s, p}) o.used = 1'b1;
			end
		end
		o.sig_cnt = sig_fill[6:0];
		o.used_cnt = used_fill[5:0];
		outcomes.push_back(o);
	endtask

	task automatic check_result();
		outcome_t o;
		if (outcomes.size() == 0) begin
			$display("%0t result with nothing outstanding", $realtime);
			fail_count++;
			return;
		end
		o = outcomes.pop_front();
		if (status !== o.st) report("status", 32'(status), 32'(o.st));
		if (sat_system !== o.sys) report("sat_system", 32'(sat_system), 32'(o.sys));
		if (sat_prn !== o.prn) report("sat_prn", 32'(sat_prn), 32'(o.prn));
		if (band !== o.bnd) report("band", 32'(band), 32'(o.bnd));
		if (sat_used !== o.used) report("sat_used", 32'(sat_used), 32'(o.used));
		if (signal_count !== o.sig_cnt)
			report("signal_count", 32'(signal_count), 32'(o.sig_cnt));
		if (used_count !== o.used_cnt)
			report("used_count", 32'(used_count), 32'(o.used_cnt));
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outcomes.delete();
			sig_fill = 0;
			used_fill = 0;
			sig_timeout = TIMEOUT_RESET;
			used_timeout = TIMEOUT_RESET;
			pending <= 0;
		end else begin
			if (result_valid) check_result();
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SIGNAL_TIMEOUT) sig_timeout = cfg_data;
				else used_timeout = cfg_data;
			end
			if (start && !busy) predict_transfer();
			pending <= outcomes.size();
		end
	end
endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
module testbench;
	import gsst_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int PHASE_ITEMS = 116;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] command = '0;
	logic [2:0] system = '0;
	logic [7:0] raw_prn = '0;
	logic [3:0] signal_id = '0;
	logic signed [7:0] elevation = '0;
	logic [8:0] azimuth = '0;
	logic [7:0] cno = '0;
	logic [31:0] now_ms = '0;
	logic cfg_valid = 1'b0;
	logic [0:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic busy, cfg_ready, result_valid, sat_used;
	logic [2:0] status, sat_system;
	logic [7:0] sat_prn;
	logic [1:0] band;
	logic [6:0] signal_count;
	logic [5:0] used_count;
	int fail_count, pending, idle_cycles;
	logic [31:0] clock_ms = '0;
	bit no_gaps = 0;

	always #5 clk = ~clk;

	gnss_satellite_signal_tracker dut (.*);

	tracker_checker chk (.*);

	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else idle_cycles <= idle_cycles + 1;
	end

	task automatic send(logic [1:0] c, logic [2:0] s, logic [7:0] p, logic [3:0] id,
			logic [7:0] el, logic [8:0] az, logic [7:0] cn, logic [31:0] t);
		int gap;
		gap = no_gaps ? 0 : int'($urandom_range(0, 16));
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		command <= c;
		system <= s;
		raw_prn <= p;
		signal_id <= id;
		elevation <= el;
		azimuth <= az;
		cno <= cn;
		now_ms <= t;
		do @(posedge clk); while (busy);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic random_item();
		int r;
		logic [2:0] s;
		logic [7:0] p;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
		else clock_ms += $urandom_range(0, 3000);
		if ($urandom_range(0, 1)) begin
			s = SYS_GPS;
			case ($urandom_range(0, 4))
				0: p = 8'($urandom_range(1, 32));
				1: p = 8'($urandom_range(33, 64));
				2: p = 8'($urandom_range(65, 96));
				3: p = 8'($urandom_range(120, 158));
				default: p = 8'($urandom_range(193, 202));
			endcase
		end else begin
			s = 3'($urandom_range(0, 7));
			p = 8'($urandom_range(0, 255));
		end
		if (r < 8)
			send({1'b1, 1'($urandom)}, 3'($urandom), 8'($urandom), 4'($urandom),
				8'($urandom), 9'($urandom), 8'($urandom), clock_ms);
		else if (r < 13)
			send(2'($urandom), 3'($urandom), 8'($urandom), 4'($urandom), 8'($urandom),
				9'($urandom), 8'($urandom), $urandom);
		else if (r < 38)
			send(2'd1, s, p, 4'($urandom), 8'($urandom), 9'($urandom), 8'($urandom),
				clock_ms);
		else
			send(2'd0, s, p, 4'($urandom), 8'($urandom), 9'($urandom_range(0, 511)),
				8'($urandom), clock_ms);
	endtask

	initial begin
		logic [31:0] sig_set[5];
		logic [31:0] used_set[5];
		sig_set = '{32'd10000, 32'd0, 32'hFFFF_FFFF, 32'd5000, $urandom_range(0, 60000)};
		used_set = '{32'd10000, 32'd0, 32'hFFFF_FFFF, 32'd20000, $urandom_range(0, 60000)};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(2'd0, SYS_GPS, 8'd0, 4'd0, 8'd0, 9'd0, 8'd0, 32'd0);
		send(2'd0, SYS_GPS, 8'd1, 4'd5, 8'h80, 9'd0, 8'd255, 32'd0);
		send(2'd0, SYS_GPS, 8'd32, 4'd7, 8'h7F, 9'd511, 8'd99, 32'hFFFF_FFFF);
		send(2'd0, SYS_SBS, 8'd33, 4'd1, 8'd45, 9'd359, 8'd100, 32'd10);
		send(2'd0, SYS_UNK, 8'd64, 4'd1, 8'hA6, 9'd180, 8'd40, 32'd20);
		send(2'd0, SYS_GPS, 8'd120, 4'd0, 8'd5, 9'd1, 8'd30, 32'd30);
		send(2'd0, SYS_GPS, 8'd158, 4'd0, 8'd5, 9'd1, 8'd30, 32'd30);
		send(2'd0, SYS_GPS, 8'd193, 4'd8, 8'd5, 9'd1, 8'd30, 32'd40);
		send(2'd0, SYS_GPS, 8'd202, 4'd6, 8'd5, 9'd1, 8'd30, 32'd40);
		send(2'd0, SYS_GPS, 8'd65, 4'd3, 8'd5, 9'd1, 8'd30, 32'd50);
		send(2'd0, SYS_GPS, 8'd96, 4'd4, 8'd5, 9'd1, 8'd30, 32'd50);
		send(2'd0, SYS_UNK, 8'd200, 4'd2, 8'd5, 9'd1, 8'd30, 32'd60);
		send(2'd0, SYS_UNK, 8'd255, 4'd2, 8'd5, 9'd1, 8'd30, 32'd60);
		send(2'd0, SYS_GAL, 8'd3, 4'd2, 8'd5, 9'd1, 8'd30, 32'd70);
		send(2'd0, SYS_BDS, 8'd40, 4'hB, 8'd5, 9'd1, 8'd30, 32'd70);
		send(2'd0, SYS_BDS, 8'd40, 4'h9, 8'd5, 9'd1, 8'd30, 32'd70);
		send(2'd0, SYS_NAV, 8'd7, 4'd4, 8'd5, 9'd1, 8'd30, 32'd80);
		send(2'd0, SYS_GPS, 8'd1, 4'd5, 8'd10, 9'd20, 8'd30, 32'd90);
		send(2'd1, SYS_GPS, 8'd1, 4'd5, 8'd0, 9'd0, 8'd0, 32'd90);
		send(2'd1, SYS_GPS, 8'd1, 4'd5, 8'd0, 9'd0, 8'd0, 32'd95);
		send(2'd1, SYS_UNK, 8'd250, 4'd0, 8'd0, 9'd0, 8'd0, 32'd95);
		send(2'd2, SYS_GPS, 8'd0, 4'd0, 8'd0, 9'd0, 8'd0, 32'd10020);
		send(2'd3, SYS_UNK, 8'd255, 4'hF, 8'hFF, 9'h1FF, 8'hFF, 32'd10100);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			write_reg(REG_SIGNAL_TIMEOUT, sig_set[ph]);
			write_reg(REG_USED_TIMEOUT, used_set[ph]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0) no_gaps = $urandom_range(0, 2) == 0;
				random_item();
			end
			drain();
		end

		if (fail_count == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end
endmodule

### filelist.f
hw/rtl/gsst_pkg.sv
hw/rtl/gsst_classify.sv
hw/rtl/gnss_satellite_signal_tracker.sv
sim/tracker_checker.sv
sim/testbench.sv
